/* sv/isl_pkg.sv */
// ----------------------------------------------------------------------------
// isl_pkg
// Shared types and constants for the indexed shift list: payload structs,
// operation codes and the per-cell command broadcast.
// ----------------------------------------------------------------------------
package isl_pkg;

	localparam int CAPACITY = 64;
	localparam int ITEM_W   = 32;
	localparam int OP_W     = 3;
	localparam int INDEX_W  = 6;
	localparam int VALUE_W  = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int GRP_SIZE = 8;
	localparam int GROUPS   = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_DELETE = 3'd2,
		OP_WRITE  = 3'd3,
		OP_READ   = 3'd4,
		OP_CLEAR  = 3'd5
	} op_e;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [INDEX_W-1:0] index;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic [VALUE_W-1:0] read_value;
		logic [CNT_W-1:0]   count;
		logic               empty_res;
	} rsp_t;

	typedef struct packed {
		logic              do_append;
		logic              do_insert;
		logic              do_delete;
		logic              do_write;
		logic [CNT_W-1:0]  idx;
		logic [CNT_W-1:0]  count;
		logic [ITEM_W-1:0] value;
	} cell_cmd_t;

endpackage

/* sv/isl_cell.sv */
// ----------------------------------------------------------------------------
// isl_cell
// One list slot. Loads the new item, takes its lower neighbor on insert,
// takes its upper neighbor on delete, else holds. Drives its item onto the
// read tree when its position matches the request index.
// ----------------------------------------------------------------------------
module isl_cell
	import isl_pkg::*;
(
	input  logic              clk,
	input  cell_cmd_t         cmd,
	input  logic [CNT_W-1:0]  pos,
	input  logic [ITEM_W-1:0] lower_data,
	input  logic [ITEM_W-1:0] upper_data,
	output logic [ITEM_W-1:0] data,
	output logic [ITEM_W-1:0] sel_data
);

	logic [ITEM_W-1:0] data_q;
	logic [ITEM_W-1:0] data_d;
	logic [CNT_W:0]    pos_inc;

	assign pos_inc = {1'b0, pos} + {{CNT_W{1'b0}}, 1'b1};

	always_comb begin
		data_d = data_q;
		if (cmd.do_append && pos == cmd.count) begin
			data_d = cmd.value;
		end
		if (cmd.do_insert) begin
			if (pos == cmd.idx) begin
				data_d = cmd.value;
			end else if (pos > cmd.idx && pos <= cmd.count) begin
				data_d = lower_data;
			end
		end
		// close the gap: every slot from the index up to the new top moves down
		if (cmd.do_delete && pos >= cmd.idx && pos_inc < {1'b0, cmd.count}) begin
			data_d = upper_data;
		end
		if (cmd.do_write && pos == cmd.idx) begin
			data_d = cmd.value;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data     = data_q;
	assign sel_data = (pos == cmd.idx) ? data_q : '0;

endmodule

/* sv/indexed_shift_list.sv */
// Indexed shift list: a row of CAPACITY slot cells that all shift in parallel.
// Pipeline: an accepted request updates the state and registers the read tree
// first level, then the final read OR is captured in the response register.
// Throughput: 1 item per cycle; the only stall is a full response register.
// Reset: arst_n clears the item count and the pipeline valid flags; slot
// contents are not reset and are only read below the count.
module indexed_shift_list
	import isl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_d;
	logic [CNT_W-1:0]  idx_ext;
	logic              full;
	logic              fire;
	logic              ok;
	logic              rd_en;
	cell_cmd_t         cmd;

	logic [ITEM_W-1:0] cell_data [CAPACITY];
	logic [ITEM_W-1:0] cell_sel  [CAPACITY];
	logic [ITEM_W-1:0] grp_or    [GROUPS];

	logic              valid_s1;
	logic              ok_s1;
	logic              rd_en_s1;
	logic [CNT_W-1:0]  count_s1;
	logic [ITEM_W-1:0] grp_s1 [GROUPS];
	logic              adv_s1;
	logic [ITEM_W-1:0] rd_or;

	logic              rsp_valid_q;
	rsp_t              rsp_q;

	assign fire    = req_valid && req_ready;
	assign idx_ext = CNT_W'(req.index);
	assign full    = (cnt_q == CNT_W'(CAPACITY));

	always_comb begin
		ok    = 1'b0;
		rd_en = 1'b0;
		cnt_d = cnt_q;
		unique case (op_e'(req.operation))
			OP_APPEND: begin
				ok = !full;
				if (ok) cnt_d = cnt_q + CNT_W'(1);
			end
			OP_INSERT: begin
				ok = !full && (idx_ext <= cnt_q);
				if (ok) cnt_d = cnt_q + CNT_W'(1);
			end
			OP_DELETE: begin
				ok = idx_ext < cnt_q;
				if (ok) cnt_d = cnt_q - CNT_W'(1);
			end
			OP_WRITE: begin
				ok = idx_ext < cnt_q;
			end
			OP_READ: begin
				ok    = idx_ext < cnt_q;
				rd_en = ok;
			end
			OP_CLEAR: begin
				ok    = 1'b1;
				cnt_d = '0;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		cmd.do_append = fire && ok && (op_e'(req.operation) == OP_APPEND);
		cmd.do_insert = fire && ok && (op_e'(req.operation) == OP_INSERT);
		cmd.do_delete = fire && ok && (op_e'(req.operation) == OP_DELETE);
		cmd.do_write  = fire && ok && (op_e'(req.operation) == OP_WRITE);
		cmd.idx       = idx_ext;
		cmd.count     = cnt_q;
		cmd.value     = req.value[ITEM_W-1:0];
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ITEM_W-1:0] lower;
		logic [ITEM_W-1:0] upper;
		if (i == 0) begin : g_first
			assign lower = '0;
		end else begin : g_lo
			assign lower = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign upper = '0;
		end else begin : g_hi
			assign upper = cell_data[i+1];
		end
		isl_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.pos        (CNT_W'(i)),
			.lower_data (lower),
			.upper_data (upper),
			.data       (cell_data[i]),
			.sel_data   (cell_sel[i])
		);
	end

	// first level of the read tree: OR each group of cells
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			grp_or[g] = '0;
			for (int k = 0; k < GRP_SIZE; k++) begin
				if (g * GRP_SIZE + k < CAPACITY) begin
					grp_or[g] = grp_or[g] | cell_sel[g * GRP_SIZE + k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (fire) begin
			cnt_q <= cnt_d;
		end
	end

	assign adv_s1    = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ok_s1    <= ok;
			rd_en_s1 <= rd_en;
			count_s1 <= cnt_d;
			grp_s1   <= grp_or;
		end
	end

	always_comb begin
		rd_or = '0;
		for (int g = 0; g < GROUPS; g++) begin
			rd_or = rd_or | grp_s1[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_q.ok         <= ok_s1;
			rsp_q.read_value <= rd_en_s1 ? VALUE_W'(rd_or) : '0;
			rsp_q.count      <= count_s1;
			rsp_q.empty_res  <= (count_s1 == '0);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("item count above capacity");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op_e'(req.operation) == OP_CLEAR |=> cnt_q == '0)
		else $error("clear did not empty the list");

	a_read_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.read_value != '0 |-> rsp_q.ok)
		else $error("read data on a rejected item");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> rsp_q.empty_res == (rsp_q.count == '0))
		else $error("empty flag disagrees with count");

endmodule
